/* design/tcc_pkg.sv */
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_HT    = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_QCAP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SCR_NONE,
        SCR_UP,
        SCR_DOWN
    } t_scroll;

endpackage

/* design/text_console_cursor_engine.sv */
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+-------------------------------------
// input     | in        | i_in_valid / o_in_ready     | command, char_code, query_row/col
// result    | out       | o_out_valid / i_out_ready   | cursor_line/column, cell_char/colour
// config    | in        | i_cfg_valid / o_cfg_ready   | text_attribute (i_cfg_data)
//
// Put without scroll, out-of-range read and unused commands go straight to the finish step; an in-range read
// passes through a capture step first. Scroll: one read and one write of the screen RAM per cell.
// Clear: one RAM write per cell.
// After reset a pass over all ROWS*COLUMNS cells zeroes the RAM; no item is taken meanwhile.
// o_in_ready is high only between items; a full result register stalls the finish step.
module text_console_cursor_engine
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_query_row,
    input  logic [COL_W-1:0]  i_query_col,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ROW_W-1:0]  o_cursor_line,
    output logic [COL_W-1:0]  o_cursor_column,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic [ATTR_W-1:0] o_cell_colour,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ATTR_W-1:0] i_cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int QW    = ROW_W + COL_W;
    localparam int DW    = CHAR_W + ATTR_W;

    localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_SCROLL = AW'(COLUMNS * (ROWS - 1) - 1);
    localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);

    logic [DW-1:0] r_mem [CELLS];
    logic [DW-1:0] r_rdata;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic              r_up, n_up;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ATTR_W-1:0] r_attr;
    logic [CHAR_W-1:0] r_res_ch, n_res_ch;
    logic [ATTR_W-1:0] r_res_colr, n_res_colr;
    logic              r_out_valid, n_out_valid;
    logic [ROW_W-1:0]  r_o_line, n_o_line;
    logic [COL_W-1:0]  r_o_column, n_o_column;
    logic [CHAR_W-1:0] r_o_char, n_o_char;
    logic [ATTR_W-1:0] r_o_colour, n_o_colour;

    logic              w_accept;
    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [DW-1:0]     w_wdata;
    logic [QW-1:0]     w_qfull, w_cfull;
    logic              w_qin;

    logic [ROW_W-1:0]  w_mv_row;
    logic [COL_W-1:0]  w_mv_col;
    t_scroll           w_scr;
    logic              w_wr_cell;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_accept        = i_in_valid && o_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_cursor_line   = r_o_line;
    assign o_cursor_column = r_o_column;
    assign o_cell_char     = r_o_char;
    assign o_cell_colour   = r_o_colour;

    assign w_qfull = QW'(i_query_row) * QW'(COLUMNS) + QW'(i_query_col);
    assign w_cfull = QW'(r_row) * QW'(COLUMNS) + QW'(r_col);
    assign w_qin   = ({1'b0, i_query_row} < (ROW_W + 1)'(ROWS))
                  && ({1'b0, i_query_col} < (COL_W + 1)'(COLUMNS));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // cursor movement for a put
    always_comb begin
        w_mv_row  = r_row;
        w_mv_col  = r_col;
        w_scr     = SCR_NONE;
        w_wr_cell = 1'b0;
        case (i_char_code)
            CH_BS: begin
                if (r_col == '0) begin
                    w_mv_col = COL_W'(COLUMNS - 1);
                    if (r_row == '0) begin
                        w_scr = SCR_DOWN;
                    end else begin
                        w_mv_row = r_row - 1'b1;
                    end
                end else begin
                    w_mv_col = r_col - 1'b1;
                end
            end
            CH_LF: begin
                if (r_row == ROW_W'(ROWS - 1)) begin
                    w_scr = SCR_UP;
                end else begin
                    w_mv_row = r_row + 1'b1;
                end
            end
            CH_VT: begin
                if (r_row == '0) begin
                    w_scr = SCR_DOWN;
                end else begin
                    w_mv_row = r_row - 1'b1;
                end
            end
            CH_CR: begin
                w_mv_col = '0;
            end
            default: begin
                if (i_char_code == CH_HT
                    || i_char_code inside {[CH_SPACE : CH_DEL - 8'd1]}) begin
                    w_wr_cell = (i_char_code != CH_HT);
                    if (r_col == COL_W'(COLUMNS - 1)) begin
                        w_mv_col = '0;
                        if (r_row == ROW_W'(ROWS - 1)) begin
                            w_scr = SCR_UP;
                        end else begin
                            w_mv_row = r_row + 1'b1;
                        end
                    end else begin
                        w_mv_col = r_col + 1'b1;
                    end
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_up        = r_up;
        n_row       = r_row;
        n_col       = r_col;
        n_res_ch    = r_res_ch;
        n_res_colr  = r_res_colr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_line    = r_o_line;
        n_o_column  = r_o_column;
        n_o_char    = r_o_char;
        n_o_colour  = r_o_colour;
        case (r_state)
            S_INIT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_res_ch   = '0;
                    n_res_colr = '0;
                    n_state    = S_DONE;
                    case (i_command)
                        CMD_PUT: begin
                            n_row = w_mv_row;
                            n_col = w_mv_col;
                            if (w_scr != SCR_NONE) begin
                                n_up    = (w_scr == SCR_UP);
                                n_cnt   = (w_scr == SCR_UP) ? '0 : LAST_SCROLL;
                                n_state = S_SCR_RD;
                            end
                        end
                        CMD_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_cnt   = '0;
                            n_state = S_FILL;
                        end
                        CMD_READ: begin
                            if (w_qin) begin
                                n_state = S_QCAP;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCR_RD: begin
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                if ((r_up && r_cnt == LAST_SCROLL) || (!r_up && r_cnt == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt   = r_up ? r_cnt + 1'b1 : r_cnt - 1'b1;
                    n_state = S_SCR_RD;
                end
            end
            S_FILL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_state = S_DONE;
                end
            end
            S_QCAP: begin
                n_res_ch   = r_rdata[CHAR_W-1:0];
                n_res_colr = r_rdata[DW-1:CHAR_W];
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_line    = r_row;
                    n_o_column  = r_col;
                    n_o_char    = r_res_ch;
                    n_o_colour  = r_res_colr;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // RAM port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = r_rdata;
        w_raddr = r_up ? r_cnt + ROW_STEP : r_cnt;
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            S_IDLE: begin
                w_raddr = w_qfull[AW-1:0];
                w_waddr = w_cfull[AW-1:0];
                w_wdata = {r_attr, i_char_code};
                w_we    = w_accept && (i_command == CMD_PUT) && w_wr_cell;
            end
            S_SCR_WR: begin
                w_we    = 1'b1;
                w_waddr = r_up ? r_cnt : r_cnt + ROW_STEP;
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_wdata = {r_attr, CH_SPACE};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_up        <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_up        <= n_up;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_ch   <= n_res_ch;
        r_res_colr <= n_res_colr;
        r_o_line   <= n_o_line;
        r_o_column <= n_o_column;
        r_o_char   <= n_o_char;
        r_o_colour <= n_o_colour;
    end

endmodule
